/* rtl/ole_pkg.sv */
// Shared types and codes for the ordered list engine.
// Item structs, request and status codes, controller/datapath command and status bundles.
// No dependencies.
package ole_pkg;

   // request codes
   localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [2:0] OP_POP_FRONT  = 3'd2;
   localparam logic [2:0] OP_POP_BACK   = 3'd3;
   localparam logic [2:0] OP_INSERT     = 3'd4;
   localparam logic [2:0] OP_FIND       = 3'd5;

   // result status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_UNDERFLOW = 2'd1;
   localparam logic [1:0] ST_BAD_POS   = 2'd2;
   localparam logic [1:0] ST_FULL      = 2'd3;

   typedef struct packed {
      logic [2:0]         req_type;
      logic signed [31:0] item_value;
      logic [5:0]         position;
   } req_item_type;

   typedef struct packed {
      logic [1:0] status;
      logic       found;
      logic [4:0] found_position;
      logic [5:0] length;
   } rsp_item_type;

   // work the datapath asks for after decoding a request
   typedef enum logic [2:0] {
      KIND_DONE       = 3'd0,
      KIND_PLACE      = 3'd1,
      KIND_SHIFT_UP   = 3'd2,
      KIND_SHIFT_DOWN = 3'd3,
      KIND_SEARCH     = 3'd4
   } kind_type;

   typedef struct packed {
      logic load;
      logic start;
      logic step_up;
      logic step_down;
      logic search;
      logic place;
      logic commit;
   } cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     up_last;
      logic     down_last;
      logic     hit;
      logic     search_end;
   } stat_type;

endpackage

/* rtl/ordered_list_engine.sv */
// Top level of the ordered list engine: bounded list with push/pop at both ends,
// positional insert and linear find. Depends on ole_pkg, ole_ctrl, ole_dp.
//
//   channel   ports                          payload          direction
//   request   req_valid, req_ready           req_item         in
//   result    rsp_valid, rsp_ready           rsp_item         out
//
// Sequence: one item at a time; each is accepted, decoded, and its result is loaded
//   into the result register. Pop back, find on an empty list, unused codes and
//   rejected requests do no RAM work; push back, insert at the end and push front
//   on an empty list write one entry. Push front and insert move one entry per
//   cycle through the entry RAM (length - position moves) and then write the new
//   entry; pop front moves length - 1 entries; find reads entries in order until
//   the first match or the end of the list. The worst case is set by the single
//   read and write port pair of the entry RAM.
// Reset: clears the entry count and control state; the list is empty at once,
//   with no clearing pass over the RAM.
// Stalls: a result waits in the output register while the next item is taken
//   and worked; that item holds its result until the register frees.
module ordered_list_engine #(
   parameter int CAPACITY    = 32,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  ole_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output ole_pkg::rsp_item_type rsp_item
);

   // command and status between sequencer and datapath
   ole_pkg::cmd_type  cmd;
   ole_pkg::stat_type stat;

   ole_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ole_dp #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_item (req_item),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_item (rsp_item)
   );

endmodule

/* rtl/ole_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module ole_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

/* rtl/ole_ctrl.sv */
// Sequencer for the ordered list engine: handshakes and the per-request walk.
// Depends on ole_pkg.
module ole_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  ole_pkg::stat_type stat,
   output ole_pkg::cmd_type  cmd
);

   typedef enum logic [8:0] {
      S_IDLE       = 9'b000000001,
      S_DISPATCH   = 9'b000000010,
      S_SHIFT_UP   = 9'b000000100,
      S_SHIFT_DOWN = 9'b000001000,
      S_DRAIN_UP   = 9'b000010000,
      S_DRAIN_DOWN = 9'b000100000,
      S_PLACE      = 9'b001000000,
      S_SEARCH     = 9'b010000000,
      S_FINISH     = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            cmd.load = req_valid;
            if (req_valid) begin
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            cmd.start = 1'b1;
            case (stat.kind)
               ole_pkg::KIND_PLACE:      state_in = S_PLACE;
               ole_pkg::KIND_SHIFT_UP:   state_in = S_SHIFT_UP;
               ole_pkg::KIND_SHIFT_DOWN: state_in = S_SHIFT_DOWN;
               ole_pkg::KIND_SEARCH:     state_in = S_SEARCH;
               default:                  state_in = S_FINISH;
            endcase
         end
         S_SHIFT_UP: begin
            cmd.step_up = 1'b1;
            if (stat.up_last) begin
               state_in = S_DRAIN_UP;
            end
         end
         S_SHIFT_DOWN: begin
            cmd.step_down = 1'b1;
            if (stat.down_last) begin
               state_in = S_DRAIN_DOWN;
            end
         end
         S_DRAIN_UP: begin
            state_in = S_PLACE;
         end
         S_DRAIN_DOWN: begin
            state_in = S_FINISH;
         end
         S_PLACE: begin
            cmd.place = 1'b1;
            state_in  = S_FINISH;
         end
         S_SEARCH: begin
            cmd.search = 1'b1;
            if (stat.hit || stat.search_end) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            // hold here until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

/* rtl/ole_dp.sv */
// Datapath for the ordered list engine: request registers, count, walk index,
// entry RAM, key compare and output register. Depends on ole_pkg and ole_ram.
module ole_dp #(
   parameter int CAPACITY    = 32,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ole_pkg::req_item_type req_item,
   input  ole_pkg::cmd_type      cmd,
   output ole_pkg::stat_type     stat,
   output ole_pkg::rsp_item_type rsp_item
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int EW = (CW > 6) ? CW : 6;

   logic [2:0]             op_ff, op_in;
   logic [VALUE_WIDTH-1:0] val_ff, val_in;
   logic [5:0]             pos_ff, pos_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [CW-1:0]          idx_ff, idx_in;
   logic                   pend_wr_ff, pend_wr_in;
   logic [CW-1:0]          pend_addr_ff, pend_addr_in;
   logic                   cmp_valid_ff, cmp_valid_in;
   logic [CW-1:0]          cmp_addr_ff, cmp_addr_in;
   logic                   found_ff, found_in;
   logic [AW-1:0]          fpos_ff, fpos_in;
   ole_pkg::rsp_item_type  rsp_ff, rsp_in;

   logic                   is_push, is_pop, is_ins, full, empty, pos_bad;
   logic                   grows, shrinks;
   logic [1:0]             status;
   logic [CW-1:0]          target, last_idx;
   logic [EW-1:0]          pos_ext;
   ole_pkg::kind_type      kind;

   logic                   wr_en, rd_en;
   logic [AW-1:0]          wr_addr, rd_addr;
   logic [VALUE_WIDTH-1:0] wr_data, rd_data;

   // decode the held request against the current count
   always_comb begin
      is_push  = (op_ff == ole_pkg::OP_PUSH_FRONT) || (op_ff == ole_pkg::OP_PUSH_BACK);
      is_pop   = (op_ff == ole_pkg::OP_POP_FRONT) || (op_ff == ole_pkg::OP_POP_BACK);
      is_ins   = (op_ff == ole_pkg::OP_INSERT);
      full     = (count_ff == CW'(CAPACITY));
      empty    = (count_ff == '0);
      pos_ext  = EW'(pos_ff);
      pos_bad  = is_ins && (pos_ext > EW'(count_ff));
      last_idx = count_ff - CW'(1);

      if (is_ins && pos_bad) begin
         status = ole_pkg::ST_BAD_POS;
      end else if ((is_ins || is_push) && full) begin
         status = ole_pkg::ST_FULL;
      end else if (is_pop && empty) begin
         status = ole_pkg::ST_UNDERFLOW;
      end else begin
         status = ole_pkg::ST_OK;
      end

      grows   = (status == ole_pkg::ST_OK) && (is_push || is_ins);
      shrinks = (status == ole_pkg::ST_OK) && is_pop;

      if (is_ins) begin
         target = pos_ext[CW-1:0];
      end else if (op_ff == ole_pkg::OP_PUSH_FRONT) begin
         target = '0;
      end else begin
         target = count_ff;
      end

      if (grows) begin
         kind = (target == count_ff) ? ole_pkg::KIND_PLACE : ole_pkg::KIND_SHIFT_UP;
      end else if (shrinks && (op_ff == ole_pkg::OP_POP_FRONT) && (count_ff != CW'(1))) begin
         kind = ole_pkg::KIND_SHIFT_DOWN;
      end else if ((op_ff == ole_pkg::OP_FIND) && !empty) begin
         kind = ole_pkg::KIND_SEARCH;
      end else begin
         kind = ole_pkg::KIND_DONE;
      end
   end

   assign stat.kind       = kind;
   assign stat.up_last    = (idx_ff == target);
   assign stat.down_last  = (idx_ff == last_idx);
   assign stat.hit        = cmp_valid_ff && (rd_data == val_ff);
   assign stat.search_end = cmp_valid_ff && (cmp_addr_ff == last_idx);

   always_comb begin
      op_in        = op_ff;
      val_in       = val_ff;
      pos_in       = pos_ff;
      idx_in       = idx_ff;
      found_in     = found_ff;
      fpos_in      = fpos_ff;
      pend_wr_in   = cmd.step_up || cmd.step_down;
      pend_addr_in = pend_addr_ff;
      cmp_valid_in = cmd.search;
      cmp_addr_in  = idx_ff;
      count_in     = count_ff;
      rsp_in       = rsp_ff;

      if (cmd.load) begin
         op_in  = req_item.req_type;
         val_in = VALUE_WIDTH'(req_item.item_value);
         pos_in = req_item.position;
      end

      if (cmd.start) begin
         found_in = 1'b0;
         fpos_in  = '0;
         case (kind)
            ole_pkg::KIND_SHIFT_UP:   idx_in = last_idx;
            ole_pkg::KIND_SHIFT_DOWN: idx_in = CW'(1);
            default:                  idx_in = '0;
         endcase
      end

      // move entry idx one place toward the back
      if (cmd.step_up) begin
         pend_addr_in = idx_ff + CW'(1);
         idx_in       = idx_ff - CW'(1);
      end

      // move entry idx one place toward the front
      if (cmd.step_down) begin
         pend_addr_in = idx_ff - CW'(1);
         idx_in       = idx_ff + CW'(1);
      end

      if (cmd.search) begin
         idx_in = idx_ff + CW'(1);
         if (stat.hit) begin
            found_in = 1'b1;
            fpos_in  = cmp_addr_ff[AW-1:0];
         end
      end

      if (cmd.commit) begin
         count_in              = count_ff + CW'(grows) - CW'(shrinks);
         rsp_in.status         = status;
         rsp_in.found          = found_ff;
         rsp_in.found_position = 5'(fpos_ff);
         rsp_in.length         = 6'(count_in);
      end
   end

   // pending shift write wins the port; the new value lands after the drain
   always_comb begin
      rd_en   = cmd.step_up || cmd.step_down || cmd.search;
      rd_addr = idx_ff[AW-1:0];
      if (pend_wr_ff) begin
         wr_en   = 1'b1;
         wr_addr = pend_addr_ff[AW-1:0];
         wr_data = rd_data;
      end else begin
         wr_en   = cmd.place;
         wr_addr = target[AW-1:0];
         wr_data = val_ff;
      end
   end

   ole_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pend_wr_ff   <= 1'b0;
         cmp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         pend_wr_ff   <= pend_wr_in;
         cmp_valid_ff <= cmp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      val_ff       <= val_in;
      pos_ff       <= pos_in;
      idx_ff       <= idx_in;
      pend_addr_ff <= pend_addr_in;
      cmp_addr_ff  <= cmp_addr_in;
      found_ff     <= found_in;
      fpos_ff      <= fpos_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_item = rsp_ff;

endmodule

/* rtl/ole_checker.sv */
// Port-level checks for the ordered list engine, bound to the top level.
// Depends on ole_pkg and ordered_list_engine.
module ole_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input ole_pkg::req_item_type req_item,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input ole_pkg::rsp_item_type rsp_item
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_item))
      else $error("result changed while stalled");

   // one item in work at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item taken while another is in work");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.found |-> rsp_item.status == ole_pkg::ST_OK
         && rsp_item.length != 6'd0)
      else $error("match reported with error status or empty list");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.found |-> rsp_item.found_position == 5'd0)
      else $error("position reported without a match");

endmodule

bind ordered_list_engine ole_checker u_ole_checker (.*);

/* tb/sv/ordered_list_checker.sv */
`timescale 1ns / 100ps
// Result checker for the ordered list engine: watches both channels, keeps its own list
// and compares every result item with the expected one. Depends on ole_pkg.
module ordered_list_checker #(
   parameter int CAPACITY = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  ole_pkg::req_item_type req_item,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  ole_pkg::rsp_item_type rsp_item,
   output int                    mismatch_count,
   output int                    pending_count
);

   localparam int EXP_DEPTH = 64;

   logic signed [31:0]    list_vals [CAPACITY];
   int                    list_len;
   ole_pkg::rsp_item_type expected_ring [EXP_DEPTH];
   int                    ring_wr;
   int                    ring_rd;
   ole_pkg::rsp_item_type want;

   // Apply one request to the list and return the result it should produce.
   function automatic ole_pkg::rsp_item_type apply_request(input ole_pkg::req_item_type rq);
      ole_pkg::rsp_item_type r;
      int                    idx;
      bit                    hit;
      r   = '0;
      hit = 1'b0;
      case (rq.req_type)
         ole_pkg::OP_PUSH_FRONT: begin
            if (list_len >= CAPACITY) begin
               r.status = ole_pkg::ST_FULL;
            end else begin
               for (idx = list_len; idx > 0; idx--) list_vals[idx] = list_vals[idx - 1];
               list_vals[0] = rq.item_value;
               list_len++;
            end
         end
         ole_pkg::OP_PUSH_BACK: begin
            if (list_len >= CAPACITY) begin
               r.status = ole_pkg::ST_FULL;
            end else begin
               list_vals[list_len] = rq.item_value;
               list_len++;
            end
         end
         ole_pkg::OP_POP_FRONT: begin
            if (list_len == 0) begin
               r.status = ole_pkg::ST_UNDERFLOW;
            end else begin
               for (idx = 0; idx + 1 < list_len; idx++) list_vals[idx] = list_vals[idx + 1];
               list_len--;
            end
         end
         ole_pkg::OP_POP_BACK: begin
            if (list_len == 0) r.status = ole_pkg::ST_UNDERFLOW;
            else list_len--;
         end
         ole_pkg::OP_INSERT: begin
            if (int'(rq.position) > list_len) begin
               r.status = ole_pkg::ST_BAD_POS;
            end else if (list_len >= CAPACITY) begin
               r.status = ole_pkg::ST_FULL;
            end else begin
               for (idx = list_len; idx > int'(rq.position); idx--)
                  list_vals[idx] = list_vals[idx - 1];
               list_vals[rq.position] = rq.item_value;
               list_len++;
            end
         end
         ole_pkg::OP_FIND: begin
            for (idx = 0; idx < list_len; idx++) begin
               if (!hit && list_vals[idx] == rq.item_value) begin
                  hit              = 1'b1;
                  r.found          = 1'b1;
                  r.found_position = 5'(idx);
               end
            end
         end
         default: ;
      endcase
      r.length = 6'(list_len);
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         list_len = 0;
         ring_wr  = 0;
         ring_rd  = 0;
      end else begin
         if (req_valid && req_ready) begin
            expected_ring[ring_wr % EXP_DEPTH] = apply_request(req_item);
            ring_wr++;
         end
         if (rsp_valid && rsp_ready) begin
            if (ring_wr == ring_rd) begin
               $error("result item with no request outstanding: %p", rsp_item);
               mismatch_count++;
            end else begin
               want = expected_ring[ring_rd % EXP_DEPTH];
               ring_rd++;
               if (rsp_item.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_item.status);
                  mismatch_count++;
               end
               if (rsp_item.found !== want.found) begin
                  $error("found: expected %0d, got %0d", want.found, rsp_item.found);
                  mismatch_count++;
               end
               if (rsp_item.found_position !== want.found_position) begin
                  $error("found_position: expected %0d, got %0d",
                         want.found_position, rsp_item.found_position);
                  mismatch_count++;
               end
               if (rsp_item.length !== want.length) begin
                  $error("length: expected %0d, got %0d", want.length, rsp_item.length);
                  mismatch_count++;
               end
            end
         end
      end
      pending_count = ring_wr - ring_rd;
   end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// Top of the ordered list engine testbench: clock, reset, request stimulus and result sink.
// Depends on ole_pkg, ordered_list_engine and ordered_list_checker.
module tb;

   // request codes the block ignores
   localparam logic [2:0] OP_SPARE_LO = 3'd6;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;

   localparam int LIST_CAPACITY = 32;
   localparam int RANDOM_ITEMS  = 950;
   // leave some margin past the slowest item
   localparam int SETTLE_CYCLES = 48;

   // traffic shape of one random episode
   typedef enum logic [1:0] {
      MODE_FILL,
      MODE_DRAIN,
      MODE_MIX
   } load_mode_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   ole_pkg::req_item_type req_item;
   logic                  rsp_valid;
   logic                  rsp_ready;
   ole_pkg::rsp_item_type rsp_item;
   int                    mismatch_count;
   int                    pending_count;

   // rough list size, kept only to steer insert positions toward legal ones
   int           est_len;
   // when set, the sender issues items back to back
   bit           tx_quiet;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   ordered_list_engine dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   ordered_list_checker #(.CAPACITY(LIST_CAPACITY)) u_list_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_item       (req_item),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_item       (rsp_item),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   // Draw a value: often one from a small pool, so finds hit and duplicates
   // show up; otherwise any 32-bit pattern.
   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 11))
         0:       return 32'sd0;
         1:       return 32'sd1;
         2:       return -32'sd1;
         3:       return 32'sh7FFF_FFFF;
         4:       return 32'sh8000_0000;
         5:       return 32'sd42;
         6:       return -32'sd42;
         7:       return 32'sh5A5A_5A5A;
         default: return $urandom();
      endcase
   endfunction

   // Present one request item after a random gap and hold it until taken.
   task automatic send_request(input logic [2:0] op, input logic signed [31:0] value,
                               input logic [5:0] pos);
      ole_pkg::req_item_type it;
      int                    gap;
      it.req_type   = op;
      it.item_value = value;
      it.position   = pos;
      gap = tx_quiet ? 0 : $urandom_range(0, 10);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_item  <= it;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // track the size the list should now have
      case (op)
         ole_pkg::OP_PUSH_FRONT, ole_pkg::OP_PUSH_BACK:
            if (est_len < LIST_CAPACITY) est_len++;
         ole_pkg::OP_POP_FRONT, ole_pkg::OP_POP_BACK:
            if (est_len > 0) est_len--;
         ole_pkg::OP_INSERT:
            if (int'(pos) <= est_len && est_len < LIST_CAPACITY) est_len++;
         default: ;
      endcase
   endtask

   // Drop valid and hold off until every outstanding result item is back.
   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   // Result sink: after each result, stall for a random number of cycles in
   // which a result is waiting. Runs of zero stall come and go.
   initial begin : result_sink
      int stall;
      int run_left;
      bit quiet;
      rsp_ready = 1'b0;
      stall     = $urandom_range(0, 10);
      run_left  = 0;
      quiet     = 1'b0;
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            if (rsp_valid) stall--;
         end else begin
            rsp_ready <= 1'b1;
         end
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            if (run_left == 0) begin
               quiet    = ($urandom_range(0, 3) == 0);
               run_left = $urandom_range(10, 60);
            end
            run_left--;
            stall = quiet ? 0 : $urandom_range(0, 10);
         end
      end
   end

   initial begin : stimulus
      load_mode_type mode;
      logic [2:0]    op;
      logic [5:0]    pos;
      int            sent;
      int            episode_left;
      int            next_pause;
      int            pick;

      reset     = 1'b1;
      req_valid = 1'b0;
      req_item  = '0;
      est_len   = 0;
      tx_quiet  = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: empty list corners, ends of the value range, insert at
      // both ends and in the middle, first-match find, bad positions, spare codes.
      send_request(ole_pkg::OP_POP_FRONT, 32'sd0, 6'd0);          // pop on empty list
      send_request(ole_pkg::OP_POP_BACK, 32'sd0, 6'd63);
      send_request(ole_pkg::OP_FIND, 32'sd0, 6'd0);               // find on empty list
      send_request(ole_pkg::OP_INSERT, 32'sd5, 6'd1);             // insert past the end
      send_request(ole_pkg::OP_INSERT, 32'sd0, 6'd0);             // insert at zero, empty
      send_request(ole_pkg::OP_PUSH_BACK, 32'sh7FFF_FFFF, 6'd0);
      send_request(ole_pkg::OP_PUSH_FRONT, 32'sh8000_0000, 6'd0);
      send_request(ole_pkg::OP_INSERT, -32'sd1, 6'd3);            // insert at the end
      send_request(ole_pkg::OP_INSERT, 32'sd42, 6'd1);            // insert in the middle
      send_request(ole_pkg::OP_PUSH_BACK, 32'sd42, 6'd0);         // duplicate key
      send_request(ole_pkg::OP_FIND, 32'sd42, 6'd0);              // first of two matches
      send_request(ole_pkg::OP_FIND, -32'sd1, 6'd0);
      send_request(ole_pkg::OP_FIND, 32'sd12345, 6'd0);           // key absent
      send_request(ole_pkg::OP_INSERT, 32'sd7, 6'd63);            // far past the end
      send_request(ole_pkg::OP_INSERT, 32'sd7, 6'd32);
      send_request(OP_SPARE_LO, 32'sh7FFF_FFFF, 6'd63);           // ignored codes
      send_request(OP_SPARE_HI, 32'sh8000_0000, 6'd32);
      send_request(ole_pkg::OP_POP_FRONT, 32'sd0, 6'd0);
      send_request(ole_pkg::OP_POP_BACK, 32'sd0, 6'd0);
      send_request(ole_pkg::OP_FIND, 32'sh8000_0000, 6'd0);       // gone after pop front
      send_request(ole_pkg::OP_FIND, 32'sh7FFF_FFFF, 6'd0);

      // hold the sender once until the block has drained
      wait_for_results();

      // Random part: episodes that mostly grow the list (and push into a full
      // one), mostly shrink it (and pop an empty one), or mix everything.
      sent         = 0;
      episode_left = 0;
      next_pause   = 200;
      mode         = MODE_FILL;
      while (sent < RANDOM_ITEMS) begin
         if (episode_left == 0) begin
            mode         = load_mode_type'($urandom_range(0, 2));
            episode_left = $urandom_range(20, 70);
            tx_quiet     = ($urandom_range(0, 3) == 0);
         end
         episode_left--;
         if ($urandom_range(0, 49) == 0) begin
            // noise: a spare code, not counted
            send_request($urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO, pick_value(),
                         6'($urandom_range(0, 63)));
         end else begin
            pick = $urandom_range(0, 99);
            case (mode)
               MODE_FILL:
                  op = pick < 30 ? ole_pkg::OP_PUSH_FRONT :
                       pick < 60 ? ole_pkg::OP_PUSH_BACK :
                       pick < 88 ? ole_pkg::OP_INSERT :
                       pick < 94 ? ole_pkg::OP_FIND : ole_pkg::OP_POP_BACK;
               MODE_DRAIN:
                  op = pick < 35 ? ole_pkg::OP_POP_FRONT :
                       pick < 70 ? ole_pkg::OP_POP_BACK :
                       pick < 85 ? ole_pkg::OP_FIND :
                       pick < 93 ? ole_pkg::OP_INSERT : ole_pkg::OP_PUSH_BACK;
               default:
                  op = pick < 15 ? ole_pkg::OP_PUSH_FRONT :
                       pick < 30 ? ole_pkg::OP_PUSH_BACK :
                       pick < 45 ? ole_pkg::OP_POP_FRONT :
                       pick < 60 ? ole_pkg::OP_POP_BACK :
                       pick < 78 ? ole_pkg::OP_INSERT : ole_pkg::OP_FIND;
            endcase
            // inserts mostly land on a legal position, sometimes past the end
            if (op == ole_pkg::OP_INSERT && $urandom_range(0, 7) != 0)
               pos = 6'($urandom_range(0, est_len));
            else if (op == ole_pkg::OP_INSERT)
               pos = 6'($urandom_range(est_len + 1, 63));
            else
               pos = 6'($urandom_range(0, 63));
            send_request(op, pick_value(), pos);
            sent++;
            if (sent == next_pause) begin
               wait_for_results();
               next_pause += $urandom_range(150, 250);
            end
         end
      end

      // drain, then give the block time to show any stray result
      wait_for_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // bound the run well past the slowest legal one
   initial begin : watchdog
      #(5_000_000);
      $display("Mismatches found");
      $finish;
   end

endmodule
